// File: src/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and codes for the fixed-priority response-time block.
// ----------------------------------------------------------------------------
`default_nettype none

package fpr_pkg;

  // status of the shared divider, seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } fpr_div_stat_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_MET        = 3'd0,
    ST_MISSED     = 3'd1,
    ST_SKIPPED    = 3'd2,
    ST_ITER_LIMIT = 3'd3,
    ST_TABLE_FULL = 3'd4
  } status_t;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_STOP_AFTER_MISS   = 2'd0,
    REG_TOLERANCE_PERCENT = 2'd1,
    REG_ITERATION_LIMIT   = 2'd2
  } reg_index_t;

endpackage

`default_nettype wire

// File: src/fpr_ram.sv
// ----------------------------------------------------------------------------
// fpr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/fpr_div.sv
// ----------------------------------------------------------------------------
// fpr_div
// Restoring divider, one quotient bit per cycle; flags a non-zero remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module fpr_div #(
  parameter int W = 32
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire logic [W-1:0]    dividend,
  input  wire logic [W-1:0]    divisor,
  output logic      [W-1:0]    quotient,
  output logic                 rem_nz,
  output fpr_pkg::fpr_div_stat_t stat
);

  localparam int CNTW = $clog2(W + 1);

  logic [W:0]      rem;
  logic [W-1:0]    quo;
  logic [W-1:0]    dvs;
  logic [CNTW-1:0] steps;
  logic            busy;
  logic            done;
  logic [W:0]      shifted;
  logic            fits;

  assign shifted = {rem[W-1:0], quo[W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= CNTW'(W);
        rem   <= '0;
        quo   <= dividend;
        dvs   <= divisor;
      end else if (busy) begin
        rem   <= fits ? (shifted - {1'b0, dvs}) : shifted;
        quo   <= {quo[W-2:0], fits};
        steps <= steps - 1'b1;
        if (steps == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo;
  assign rem_nz    = |rem;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

`default_nettype wire

// File: src/fixed_priority_response_time.sv
// ----------------------------------------------------------------------------
// fixed_priority_response_time
// Worst-case response-time analysis of fixed-priority task sets, one task
// per item, tasks arriving highest priority first.
// ----------------------------------------------------------------------------
// Input channel s_axis: one task per item; tuser marks the first task of a
// new set. Output channel m_axis: one result per task (response time,
// status, running verdict of the set, rank). APB port holds three registers:
// stop_after_miss (0x0), tolerance_percent (0x4), iteration_limit (0x8).
// Each task is solved with one shared restoring divider of W bits,
// W = min(TIME_BITS, 32), plus one multiplier, stepping through the stored
// higher-priority tasks in a RAM: first summing their loads, then, per
// iteration, dividing, multiplying and adding one term per stored task.
// A zero or overflowing first guess ends the analysis before any iteration;
// skipped or table-full tasks go straight to the result.
// s_axis_tready is high only while no task is being worked on. The result
// sits in an output register, so a new task is taken while it waits; a
// finished task waits for the register to empty when the receiver stalls.
// Reset (rst, synchronous) empties the task table, clears the verdict,
// drops m_axis_tvalid and restores register defaults (0, 1, 1000).
// ----------------------------------------------------------------------------
`default_nettype none

module fixed_priority_response_time #(
  parameter int MAX_TASKS = 32,
  parameter int TIME_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // APB configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  // task input
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,  // task_wcet, task_period, task_deadline
  input  wire logic [0:0]  s_axis_tuser,  // start_new_set
  // result output
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [47:0] m_axis_tdata   // response_time, status, set_schedulable,
                                          // task_position, zero pad
);

  localparam int TW = (TIME_BITS < 32) ? TIME_BITS : 32;
  localparam int VW = TW + 1;        // one spare bit marks overflow
  localparam int PW = TW + 7;        // tolerance products
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  localparam logic [VW-1:0] LIM_V  = {1'b0, {TW{1'b1}}};
  localparam logic [VW-1:0] LIM_P1 = {1'b1, {TW{1'b0}}};

  typedef enum logic [3:0] {
    S_IDLE, S_SUM_RD, S_SUM_ACC, S_LOOP, S_TERM_RD, S_TERM_LATCH, S_TERM_DIV,
    S_TERM_MUL, S_TERM_ACC, S_ITER_END, S_CONV, S_FINISH, S_OUT
  } state_t;

  function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] a,
                                            input logic [VW-1:0] b);
    logic [VW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, LIM_V}) ? LIM_P1 : s[VW-1:0];
  endfunction

  function automatic logic [TW-1:0] clamp_in(input logic [31:0] v);
    logic [31:0] upper;
    upper = v >> TW;
    return (upper != 32'd0) ? LIM_V[TW-1:0] : v[TW-1:0];
  endfunction

  // configuration
  logic        stop_after_miss;
  logic [6:0]  tolerance_percent;
  logic [15:0] iteration_limit;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_after_miss   <= 1'b0;
      tolerance_percent <= 7'd1;
      iteration_limit   <= 16'd1000;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        fpr_pkg::REG_STOP_AFTER_MISS:   stop_after_miss   <= pwdata[0];
        fpr_pkg::REG_TOLERANCE_PERCENT: tolerance_percent <= pwdata[6:0];
        fpr_pkg::REG_ITERATION_LIMIT:   iteration_limit   <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      fpr_pkg::REG_STOP_AFTER_MISS:   prdata = {31'd0, stop_after_miss};
      fpr_pkg::REG_TOLERANCE_PERCENT: prdata = {25'd0, tolerance_percent};
      fpr_pkg::REG_ITERATION_LIMIT:   prdata = {16'd0, iteration_limit};
      default:                        prdata = 32'd0;
    endcase
  end

  // sequencer state
  state_t         state;
  logic [CW-1:0]  cnt;
  logic           failed;
  logic [CW-1:0]  j;
  logic [TW-1:0]  c_val;
  logic [TW-1:0]  t_val;
  logic [TW-1:0]  d_val;
  logic [VW-1:0]  r;
  logic [VW-1:0]  intf;
  logic [VW-1:0]  rn;
  logic [TW-1:0]  hi;
  logic [PW-1:0]  lhs;
  logic [PW-1:0]  rhs;
  logic [TW-1:0]  ld;
  logic [2*TW-1:0] prod;
  logic [15:0]    it;
  logic [2:0]     status;
  logic [TW-1:0]  resp;
  logic [5:0]     pos;
  logic           analysed;

  // table and divider
  logic [2*TW-1:0] rd_data;
  logic            ram_we;
  logic            div_start;
  logic [TW-1:0]   div_q;
  logic            div_nz;
  logic [TW-1:0]   period_eff;
  fpr_pkg::fpr_div_stat_t div_stat;

  assign ram_we     = (state == S_FINISH) && analysed;
  assign div_start  = (state == S_TERM_LATCH);
  assign period_eff = (rd_data[2*TW-1:TW] == '0) ? TW'(1) : rd_data[2*TW-1:TW];

  fpr_ram #(.WIDTH(2*TW), .DEPTH(MAX_TASKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[AW-1:0]),
    .wdata ({t_val, c_val}),
    .raddr (j[AW-1:0]),
    .rdata (rd_data)
  );

  fpr_div #(.W(TW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (r[TW-1:0]),
    .divisor  (period_eff),
    .quotient (div_q),
    .rem_nz   (div_nz),
    .stat     (div_stat)
  );

  // combinational helpers
  logic           accept;
  logic [CW-1:0]  cnt_eff;
  logic           failed_eff;
  logic [VW-1:0]  rn_w;
  logic [TW-1:0]  hi_w;
  logic [TW-1:0]  lo_w;
  logic [TW-1:0]  ceil_q;
  logic [VW-1:0]  term;
  logic [15:0]    max_it;
  logic [2:0]     final_status;
  logic           out_free;

  assign accept     = s_axis_tvalid && s_axis_tready;
  assign cnt_eff    = s_axis_tuser[0] ? '0 : cnt;
  assign failed_eff = s_axis_tuser[0] ? 1'b0 : failed;
  assign rn_w       = sat_add({1'b0, c_val}, intf);
  assign hi_w       = (rn_w[TW-1:0] > r[TW-1:0]) ? rn_w[TW-1:0] : r[TW-1:0];
  assign lo_w       = (rn_w[TW-1:0] > r[TW-1:0]) ? r[TW-1:0] : rn_w[TW-1:0];
  assign ceil_q     = div_q + TW'(div_nz);
  assign term       = (prod > (2*TW)'(LIM_P1)) ? LIM_P1 : prod[VW-1:0];
  assign max_it     = (iteration_limit == 16'd0) ? 16'd1 : iteration_limit;
  assign final_status = (status == fpr_pkg::ST_MET && resp > d_val) ?
                        fpr_pkg::ST_MISSED : status;
  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      failed        <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      // S_OUT reloads the register itself
      if (m_axis_tvalid && m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            c_val    <= clamp_in(s_axis_tdata[31:0]);
            t_val    <= clamp_in(s_axis_tdata[63:32]);
            d_val    <= clamp_in(s_axis_tdata[95:64]);
            cnt      <= cnt_eff;
            pos      <= 6'(cnt_eff);
            resp     <= '0;
            it       <= '0;
            j        <= '0;
            r        <= {1'b0, clamp_in(s_axis_tdata[31:0])};
            if (stop_after_miss && failed_eff) begin
              failed   <= failed_eff;
              analysed <= 1'b0;
              status   <= fpr_pkg::ST_SKIPPED;
              state    <= S_FINISH;
            end else if (cnt_eff >= CW'(MAX_TASKS)) begin
              failed   <= 1'b1;
              analysed <= 1'b0;
              status   <= fpr_pkg::ST_TABLE_FULL;
              state    <= S_FINISH;
            end else begin
              failed   <= failed_eff;
              analysed <= 1'b1;
              status   <= fpr_pkg::ST_MET;
              state    <= (cnt_eff == '0) ? S_LOOP : S_SUM_RD;
            end
          end
        end
        S_SUM_RD: state <= S_SUM_ACC;
        S_SUM_ACC: begin
          r <= sat_add(r, {1'b0, rd_data[TW-1:0]});
          j <= j + 1'b1;
          state <= (j + 1'b1 == cnt) ? S_LOOP : S_SUM_RD;
        end
        S_LOOP: begin
          // top of the fixed-point loop: overflow or a zero guess end it
          if (r[TW]) begin
            resp   <= LIM_V[TW-1:0];
            status <= fpr_pkg::ST_MISSED;
            state  <= S_FINISH;
          end else if (r == '0) begin
            resp  <= '0;
            state <= S_FINISH;
          end else begin
            intf  <= '0;
            j     <= '0;
            state <= (cnt == '0) ? S_ITER_END : S_TERM_RD;
          end
        end
        S_TERM_RD: state <= S_TERM_LATCH;
        S_TERM_LATCH: begin
          ld    <= rd_data[TW-1:0];
          state <= S_TERM_DIV;
        end
        S_TERM_DIV: begin
          if (div_stat.done) begin
            state <= S_TERM_MUL;
          end
        end
        S_TERM_MUL: begin
          prod  <= (2*TW)'(ceil_q) * (2*TW)'(ld);
          state <= S_TERM_ACC;
        end
        S_TERM_ACC: begin
          intf  <= sat_add(intf, term);
          j     <= j + 1'b1;
          state <= (j + 1'b1 == cnt) ? S_ITER_END : S_TERM_RD;
        end
        S_ITER_END: begin
          it <= it + 1'b1;
          if (rn_w[TW]) begin
            resp   <= LIM_V[TW-1:0];
            status <= fpr_pkg::ST_MISSED;
            state  <= S_FINISH;
          end else begin
            rn    <= rn_w;
            hi    <= hi_w;
            lhs   <= PW'(hi_w - lo_w) * PW'(100);
            rhs   <= PW'(tolerance_percent) * PW'(hi_w);
            state <= S_CONV;
          end
        end
        S_CONV: begin
          if (lhs <= rhs) begin
            resp  <= hi;
            state <= S_FINISH;
          end else if (it >= max_it) begin
            resp   <= hi;
            status <= fpr_pkg::ST_ITER_LIMIT;
            state  <= S_FINISH;
          end else begin
            r     <= rn;
            state <= S_LOOP;
          end
        end
        S_FINISH: begin
          if (analysed) begin
            status <= final_status;
            cnt    <= cnt + 1'b1;
            if (final_status != fpr_pkg::ST_MET) begin
              failed <= 1'b1;
            end
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, pos, !failed, status, 32'(resp)};
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_TASKS))
    else $error("task count beyond table depth");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_axis_tready)
    else $error("input still ready after taking an item");

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tdata[34:32] == fpr_pkg::ST_SKIPPED ||
                       m_axis_tdata[34:32] == fpr_pkg::ST_TABLE_FULL))
      |-> (m_axis_tdata[31:0] == 32'd0))
    else $error("skipped or rejected task with non-zero response");

endmodule

`default_nettype wire

// File: test/fixed_priority_response_time_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_priority_response_time_tb
// Self-checking bench for the fixed-priority response-time block. Task items
// go in over the input stream, and every result item is checked against a
// response-time solver kept in the bench. Directed tests cover the corner
// cases first. Random task sets then run under several register settings,
// with gaps and stalls on both streams except in the last run.
// ----------------------------------------------------------------------------

module fixed_priority_response_time_tb;

  localparam int MAX_TASKS = 32;
  localparam int TIME_BITS = 32;
  // cost weight of one divide term in the bench's time budget
  localparam int TERM_CYCLES = 37;

  typedef bit [63:0] u64_t;
  localparam u64_t LIMIT = 64'h0000_0000_FFFF_FFFF;

  typedef struct packed {
    bit [31:0]        response_time;
    fpr_pkg::status_t status;
    bit               set_schedulable;
    bit [5:0]         task_position;
  } analysis_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // task_wcet, task_period, task_deadline
  logic [0:0]  s_axis_tuser = '0;   // start_new_set
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // response_time, status, set_schedulable,
                                    // task_position, zero pad

  // solver state and register copies
  bit [31:0]   tbl_load [MAX_TASKS];
  bit [31:0]   tbl_period [MAX_TASKS];
  int unsigned n_stored = 0;
  bit          set_failed = 1'b0;
  bit          cfg_stop = 1'b0;
  bit [6:0]    cfg_tol = 7'd1;
  bit [15:0]   cfg_iter_limit = 16'd1000;

  analysis_t       awaited_analyses[$];
  int unsigned     error_count = 0;
  bit              idle_on = 1'b1;
  int unsigned     set_left = 0;
  int unsigned     set_len = 1;
  int              stall_left = 0;
  longint unsigned cycle_count = 0;
  longint unsigned cycle_budget = 100000;

  fixed_priority_response_time #(
    .MAX_TASKS(MAX_TASKS),
    .TIME_BITS(TIME_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // response-time solver
  // --------------------------------------------------------------------------
  function automatic u64_t add_sat(input u64_t a, input u64_t b);
    u64_t s;
    s = a + b;
    return (s > LIMIT) ? LIMIT + 1 : s;
  endfunction

  // iterates against the current table, leaves state untouched
  function automatic void solve_response(input u64_t c, output u64_t resp,
                                         output fpr_pkg::status_t st,
                                         output int unsigned iters);
    u64_t r, rn, intf, p, b, prod, hi, lo, maxit;
    bit over;
    r = c;
    over = 1'b0;
    iters = 0;
    st = fpr_pkg::ST_MET;
    maxit = (cfg_iter_limit == 0) ? 1 : cfg_iter_limit;
    for (int j = 0; j < n_stored; j++) r = add_sat(r, tbl_load[j]);
    if (r > LIMIT) over = 1'b1;
    while (!over && r != 0) begin
      intf = 0;
      for (int j = 0; j < n_stored; j++) begin
        p = (tbl_period[j] == 0) ? 1 : tbl_period[j];
        b = r / p + ((r % p != 0) ? 1 : 0);
        prod = b * tbl_load[j];
        if (prod > LIMIT + 1) prod = LIMIT + 1;
        intf = add_sat(intf, prod);
      end
      rn = add_sat(c, intf);
      iters++;
      if (rn > LIMIT) begin
        over = 1'b1;
        break;
      end
      hi = (rn > r) ? rn : r;
      lo = (rn > r) ? r : rn;
      if (100 * (hi - lo) <= cfg_tol * hi) begin
        r = hi;
        break;
      end
      if (iters >= maxit) begin
        r = hi;
        st = fpr_pkg::ST_ITER_LIMIT;
        break;
      end
      r = rn;
    end
    if (over) begin
      resp = LIMIT;
      st = fpr_pkg::ST_MISSED;
    end else begin
      resp = r;
    end
  endfunction

  function automatic void analyse_task(input bit first, input bit [31:0] c, t, d,
                                       output analysis_t res, output int unsigned cost);
    u64_t             resp;
    fpr_pkg::status_t st;
    int unsigned      iters;
    int unsigned      rank;
    if (first) begin
      n_stored = 0;
      set_failed = 1'b0;
    end
    rank = n_stored;
    resp = 0;
    iters = 0;
    st = fpr_pkg::ST_SKIPPED;
    if (cfg_stop && set_failed) begin
      st = fpr_pkg::ST_SKIPPED;
    end else if (n_stored >= MAX_TASKS) begin
      st = fpr_pkg::ST_TABLE_FULL;
      set_failed = 1'b1;
    end else begin
      solve_response(c, resp, st, iters);
      if (st == fpr_pkg::ST_MET && resp > d) st = fpr_pkg::ST_MISSED;
      if (st != fpr_pkg::ST_MET) set_failed = 1'b1;
      tbl_load[n_stored] = c;
      tbl_period[n_stored] = t;
      n_stored++;
    end
    res.response_time = resp[31:0];
    res.status = st;
    res.set_schedulable = !set_failed;
    res.task_position = rank[5:0];
    cost = 3 + 2 * rank + iters * (rank * TERM_CYCLES + 3);
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic send_task(input bit first, input bit [31:0] c, t, d);
    analysis_t   res;
    int unsigned cost;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {d, t, c};
    s_axis_tuser  <= first;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    analyse_task(first, c, t, d, res, cost);
    awaited_analyses.push_back(res);
    cycle_budget += 4 * (cost + 64);
  endtask

  task automatic wait_for_idle();
    s_axis_tvalid <= 1'b0;
    while (awaited_analyses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // leaves psel high so transfers can run back to back
  task automatic write_register(input fpr_pkg::reg_index_t idx, input bit [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      fpr_pkg::REG_STOP_AFTER_MISS:   cfg_stop = value[0];
      fpr_pkg::REG_TOLERANCE_PERCENT: cfg_tol = value[6:0];
      fpr_pkg::REG_ITERATION_LIMIT:   cfg_iter_limit = value[15:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input bit stop, input bit [6:0] tol, input bit [15:0] lim);
    wait_for_idle();
    write_register(fpr_pkg::REG_STOP_AFTER_MISS, 32'(stop));
    write_register(fpr_pkg::REG_TOLERANCE_PERCENT, 32'(tol));
    write_register(fpr_pkg::REG_ITERATION_LIMIT, 32'(lim));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cycle_budget += 1000;
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_default_settings();
    send_task(1'b1, 32'd0, 32'd1, 32'd0);         // zero guess
    send_task(1'b0, 32'd10, 32'd100, 32'd50);
    send_task(1'b0, 32'd20, 32'd200, 32'd30);     // response equals deadline
    send_task(1'b0, 32'd5, 32'd0, 32'hFFFF_FFFF); // zero period stored
    send_task(1'b0, 32'd1, 32'd1000, 32'd1000);   // diverges, saturates
    send_task(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_task(1'b0, 32'd1, 32'd1, 32'd0);         // initial sum overflows
  endtask

  task automatic test_iteration_limit();
    apply_settings(1'b0, 7'd0, 16'd1);
    send_task(1'b1, 32'd3, 32'd5, 32'd100);
    send_task(1'b0, 32'd3, 32'd5, 32'd100);
    // a limit of zero acts as one
    apply_settings(1'b0, 7'd0, 16'd0);
    send_task(1'b1, 32'd3, 32'd5, 32'd100);
    send_task(1'b0, 32'd3, 32'd5, 32'd100);
  endtask

  task automatic test_tolerance();
    apply_settings(1'b0, 7'd100, 16'hFFFF);
    send_task(1'b1, 32'd3, 32'd5, 32'd100);
    send_task(1'b0, 32'd3, 32'd5, 32'd4);
    apply_settings(1'b0, 7'd127, 16'd1000);
    send_task(1'b1, 32'd3, 32'd5, 32'd100);
    send_task(1'b0, 32'd3, 32'd5, 32'd100);
  endtask

  task automatic test_stop_after_miss();
    apply_settings(1'b1, 7'd1, 16'd1000);
    send_task(1'b1, 32'd50, 32'd100, 32'd10);
    send_task(1'b0, 32'd1, 32'd10, 32'd100);
    send_task(1'b0, 32'd2, 32'd10, 32'd100);
    send_task(1'b1, 32'd1, 32'd10, 32'd100);
  endtask

  task automatic test_table_full();
    apply_settings(1'b0, 7'd1, 16'd1000);
    // zero loads keep every guess at zero, so the fill is cheap
    for (int i = 0; i < MAX_TASKS; i++)
      send_task(i == 0, 32'd0, 32'($urandom_range(1, 1000)), $urandom);
    send_task(1'b0, 32'd7, 32'd50, 32'd100);
    send_task(1'b0, 32'd0, 32'd50, 32'd100);
    apply_settings(1'b1, 7'd1, 16'd1000);
    send_task(1'b0, 32'd1, 32'd50, 32'd100);
  endtask

  task automatic run_random_items(input int unsigned count);
    bit               first;
    bit [31:0]        c, t, d;
    u64_t             r;
    fpr_pkg::status_t st;
    int unsigned      iters;
    for (int i = 0; i < count; i++) begin
      first = 1'b0;
      if (set_left == 0) begin
        first = 1'b1;
        set_left = ($urandom_range(0, 11) == 0) ? MAX_TASKS + 4 : $urandom_range(1, 10);
        set_len = set_left;
      end
      set_left--;
      if ($urandom_range(0, 9) == 0) begin
        // noise: any values, now and then a stray set start
        c = $urandom;
        t = ($urandom_range(0, 3) == 0) ? 32'd0 : $urandom;
        d = $urandom;
        first = first | ($urandom_range(0, 7) == 0);
      end else begin
        t = $urandom_range(16, 4000);
        c = $urandom_range(0, t / (set_len + 1));
        d = ($urandom_range(0, 3) == 0) ? $urandom_range(0, c) : $urandom_range(c, t);
      end
      // a task that would iterate for ages starts a fresh set instead
      if (!first && !(cfg_stop && set_failed) && n_stored < MAX_TASKS) begin
        solve_response(c, r, st, iters);
        if (iters * (n_stored * TERM_CYCLES + 3) > 20000) first = 1'b1;
      end
      send_task(first, c, t, d);
    end
  endtask

  task automatic test_random_sets();
    apply_settings(1'b0, 7'd1, 16'd1000);
    run_random_items(70);
    apply_settings(1'b1, 7'd0, 16'hFFFF);
    run_random_items(70);
    apply_settings(1'b0, 7'd100, 16'd1);
    run_random_items(70);
    apply_settings(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                   16'($urandom_range(1, 50)));
    run_random_items(70);
    apply_settings(1'b0, 7'd5, 16'd3);
    idle_on = 1'b0;
    run_random_items(70);
  endtask

  // --------------------------------------------------------------------------
  // result side: stalls and checking
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 17) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void check_field(input string field, input bit [31:0] want,
                                      input bit [31:0] got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    analysis_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (awaited_analyses.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        error_count++;
      end else begin
        want = awaited_analyses.pop_front();
        check_field("response_time", want.response_time, m_axis_tdata[31:0]);
        check_field("status", 32'(want.status), 32'(m_axis_tdata[34:32]));
        check_field("set_schedulable", 32'(want.set_schedulable), 32'(m_axis_tdata[35]));
        check_field("task_position", 32'(want.task_position), 32'(m_axis_tdata[41:36]));
        check_field("pad", 32'd0, 32'(m_axis_tdata[47:42]));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_budget) begin
      $display("FAIL fixed_priority_response_time");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_settings();
    test_iteration_limit();
    test_tolerance();
    test_stop_after_miss();
    test_table_full();
    test_random_sets();
    wait_for_idle();
    repeat (64) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS fixed_priority_response_time");
    end else begin
      $display("FAIL fixed_priority_response_time");
    end
    $finish;
  end

endmodule

// File: files.f
src/fpr_pkg.sv
src/fpr_ram.sv
src/fpr_div.sv
src/fixed_priority_response_time.sv
test/fixed_priority_response_time_tb.sv
